// ----- src/rbd_pkg.sv -----
// Shared types and constants of the run-length bitmap decoder.
`default_nettype none

package rbd_pkg;

    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 12;
    localparam int ROW_BITS_W = 20;
    localparam int ROW_IDX_W  = 4;
    localparam int STATUS_W   = 2;

    localparam logic [CHAR_W-1:0] KIND_WALL  = 8'h77;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = 12'd4095;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FULL      = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_ERROR     = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_string;
    } char_item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]  row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [STATUS_W-1:0]   status;
        logic                  final_row;
    } row_item_t;

    typedef struct packed {
        logic accept;
        logic seg_read;
        logic seg_write;
        logic finish;
        logic dump_read;
        logic dump_load;
    } rbd_cmd_t;

    typedef struct packed {
        logic run_busy;
        logic string_done;
        logic out_busy;
        logic dump_last;
    } rbd_sts_t;

endpackage

`default_nettype wire

// ----- src/rle_bitmap_decoder.sv -----
// Top level of the run-length bitmap decoder.
`default_nettype none

// Decodes a run-length text string, one character per transfer on the char
// channel, into a MAP_COLS x MAP_ROWS bitmap. Each section is a kind character
// followed by a decimal count ('w' fills ones, any other kind zeros); counts
// saturate at 4095 and runs fill cells in raster order, column fastest. Cells
// past the last run keep their committed values, cells beyond the map are
// dropped, and a section without digits aborts the string and leaves the
// bitmap untouched. On the character flagged end_of_string the parse is
// committed (or dropped) and every row goes out on the row channel with a
// status; final_row marks the last one.
// Flow: the block takes one character at a time. After each transfer the
// sequencer checks the run walker before it takes the next character; a
// character that closes a run adds a read-modify-write of each bitmap row
// the run touches, through the single-port row banks. The end of a string
// adds a commit step and then a read and a load for each row of the dump,
// held while the row channel stalls. The last row may still wait in the
// output register while the next string is taken. No clearing pass after
// reset: per-row valid bits make unwritten rows read as zero.

module rle_bitmap_decoder
    import rbd_pkg::*;
#(
    parameter int MAP_COLS = 20,
    parameter int MAP_ROWS = 12
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire char_item_t char_data,
    output logic            row_valid,
    input  wire logic       row_stall,
    output row_item_t       row_data
);

    rbd_cmd_t cmd;
    rbd_sts_t sts;

    // sequencer: owns the char handshake and steps the datapath
    rbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    // parser, run walker, row banks and output register
    rbd_datapath #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_data (char_data),
        .cmd       (cmd),
        .sts       (sts),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row_data  (row_data)
    );

endmodule

`default_nettype wire

// ----- src/rbd_ctrl.sv -----
// Sequencer of the run-length bitmap decoder: parse, run fill, commit and row dump.
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     char_valid,
    output logic          char_stall,
    output rbd_cmd_t      cmd,
    input  wire rbd_sts_t sts
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_STEP    = 6'b000010,
        ST_SEG_WR  = 6'b000100,
        ST_FINISH  = 6'b001000,
        ST_DUMP_RD = 6'b010000,
        ST_DUMP_LD = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        char_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                char_stall = 1'b0;
                if (char_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (sts.run_busy)
                begin
                    cmd.seg_read = 1'b1;
                    state_next   = ST_SEG_WR;
                end
                else if (sts.string_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEG_WR:
            begin
                cmd.seg_write = 1'b1;
                state_next    = ST_STEP;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DUMP_RD;
            end
            ST_DUMP_RD:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.dump_read = 1'b1;
                    state_next    = ST_DUMP_LD;
                end
            end
            ST_DUMP_LD:
            begin
                cmd.dump_load = 1'b1;
                state_next    = sts.dump_last ? ST_IDLE : ST_DUMP_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rbd_datapath.sv -----
// Datapath of the run-length bitmap decoder: parser, run walker, row banks, output register.
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int MAP_COLS = 20,
    parameter int MAP_ROWS = 12
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire char_item_t char_data,
    input  wire rbd_cmd_t   cmd,
    output rbd_sts_t        sts,
    output logic            row_valid,
    input  wire logic       row_stall,
    output row_item_t       row_data
);

    localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
    localparam int CELL_W    = $clog2(MAP_CELLS + 1);
    localparam int POS_W     = (CELL_W > CNT_W) ? CELL_W : CNT_W;
    localparam int COL_W     = $clog2(MAP_COLS + 1);
    localparam int ROW_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int PROD_W    = CNT_W + 4;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_KIND   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    // parser state
    phase_t             phase_reg;
    logic               run_fill_reg;
    logic [CNT_W-1:0]   run_count_reg;
    logic               err_reg;
    logic               trunc_reg;
    logic               last_reg;

    // run walker
    logic [POS_W-1:0]   pos_reg;
    logic [ROW_W-1:0]   pos_row_reg;
    logic [COL_W-1:0]   pos_col_reg;
    logic [POS_W-1:0]   run_left_reg;
    logic               run_val_reg;

    // row banks: cur marks the bank with the committed row, dirty a row rewritten this string
    logic [MAP_COLS-1:0] mem0 [MAP_ROWS];
    logic [MAP_COLS-1:0] mem1 [MAP_ROWS];
    logic [MAP_ROWS-1:0] val0_reg;
    logic [MAP_ROWS-1:0] val1_reg;
    logic [MAP_ROWS-1:0] cur_reg;
    logic [MAP_ROWS-1:0] dirty_reg;
    logic [MAP_COLS-1:0] rd0_reg;
    logic [MAP_COLS-1:0] rd1_reg;
    logic                rd_bank_reg;
    logic                rd_ok_reg;

    // dump
    logic [ROW_W-1:0]    dump_row_reg;
    status_t             status_reg;
    logic                row_valid_reg;
    row_item_t           row_data_reg;

    // parse decode
    logic               is_digit;
    logic [CNT_W-1:0]   digit_val;
    logic [PROD_W-1:0]  prod;
    phase_t             phase_next;
    logic               fill_next;
    logic [CNT_W-1:0]   count_next;
    logic               err_next;
    logic               trunc_next;
    logic               pos_clr;
    logic               launch;
    logic [CNT_W-1:0]   launch_count;
    logic               launch_fill;
    logic [POS_W-1:0]   remaining;
    logic [POS_W-1:0]   launch_len;

    // segment decode
    logic [COL_W-1:0]    col_room;
    logic [COL_W-1:0]    seg_len;
    logic [COL_W:0]      col_end;
    logic [MAP_COLS-1:0] seg_mask;
    logic [ROW_W-1:0]    rd_addr;
    logic                rd_bank;
    logic                rd_ok;
    logic [MAP_COLS-1:0] rd_row;
    logic [MAP_COLS-1:0] new_row;
    logic                wr_bank;
    status_t             status_next;

    assign is_digit  = (char_data.character >= CHAR_ZERO) && (char_data.character <= CHAR_NINE);
    assign digit_val = CNT_W'(char_data.character - CHAR_ZERO);
    assign prod      = (PROD_W'(run_count_reg) << 3) + (PROD_W'(run_count_reg) << 1)
                     + PROD_W'(digit_val);
    assign remaining = POS_W'(MAP_CELLS) - pos_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        fill_next    = run_fill_reg;
        count_next   = run_count_reg;
        err_next     = err_reg;
        trunc_next   = trunc_reg;
        pos_clr      = 1'b0;
        launch       = 1'b0;
        launch_count = run_count_reg;
        launch_fill  = run_fill_reg;
        launch_len   = '0;
        unique case (phase_reg)
            PH_START:
            begin
                err_next   = 1'b0;
                trunc_next = 1'b0;
                pos_clr    = 1'b1;
                fill_next  = (char_data.character == KIND_WALL);
                count_next = '0;
                phase_next = PH_KIND;
            end
            PH_KIND:
            begin
                if (!err_reg)
                begin
                    if (is_digit)
                    begin
                        count_next = digit_val;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            PH_DIGITS:
            begin
                if (!err_reg)
                begin
                    if (is_digit)
                    begin
                        count_next = (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(prod);
                    end
                    else
                    begin
                        // close the section and open the next one
                        launch     = 1'b1;
                        fill_next  = (char_data.character == KIND_WALL);
                        count_next = '0;
                        phase_next = PH_KIND;
                    end
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
        if (char_data.end_of_string && !err_next)
        begin
            if (phase_next == PH_DIGITS)
            begin
                launch       = 1'b1;
                launch_count = count_next;
                launch_fill  = fill_next;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        if (launch)
        begin
            if (POS_W'(launch_count) > remaining)
            begin
                launch_len = remaining;
                trunc_next = 1'b1;
            end
            else
            begin
                launch_len = POS_W'(launch_count);
            end
        end
    end

    // segment of the current run inside the current row
    assign col_room = COL_W'(MAP_COLS) - pos_col_reg;
    assign seg_len  = (run_left_reg < POS_W'(col_room)) ? COL_W'(run_left_reg) : col_room;
    assign col_end  = {1'b0, pos_col_reg} + {1'b0, seg_len};

    always_comb
    begin
        for (int c = 0; c < MAP_COLS; c++)
        begin
            seg_mask[c] = (COL_W'(c) >= pos_col_reg) && ((COL_W + 1)'(c) < col_end);
        end
    end

    assign rd_addr = cmd.seg_read ? pos_row_reg : dump_row_reg;
    assign rd_bank = cmd.seg_read ? (cur_reg[rd_addr] ^ dirty_reg[rd_addr]) : cur_reg[rd_addr];
    assign rd_ok   = rd_bank ? val1_reg[rd_addr] : val0_reg[rd_addr];
    assign rd_row  = rd_ok_reg ? (rd_bank_reg ? rd1_reg : rd0_reg) : '0;
    assign new_row = (rd_row & ~seg_mask) | (run_val_reg ? seg_mask : '0);
    assign wr_bank = ~cur_reg[pos_row_reg];

    always_comb
    begin
        if (err_reg)
        begin
            status_next = STATUS_ERROR;
        end
        else if (trunc_reg)
        begin
            status_next = STATUS_TRUNCATED;
        end
        else if (pos_reg < POS_W'(MAP_CELLS))
        begin
            status_next = STATUS_SHORT;
        end
        else
        begin
            status_next = STATUS_FULL;
        end
    end

    // bank storage, no reset: unwritten entries read as zero through the valid bits
    always_ff @(posedge clk)
    begin
        if (cmd.seg_write)
        begin
            if (wr_bank)
            begin
                mem1[pos_row_reg] <= new_row;
            end
            else
            begin
                mem0[pos_row_reg] <= new_row;
            end
        end
        if (cmd.seg_read || cmd.dump_read)
        begin
            rd0_reg <= mem0[rd_addr];
            rd1_reg <= mem1[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dump_load)
        begin
            row_data_reg.row_index <= ROW_IDX_W'(dump_row_reg);
            row_data_reg.row_bits  <= ROW_BITS_W'(rd_row);
            row_data_reg.status    <= status_reg;
            row_data_reg.final_row <= (dump_row_reg == ROW_W'(MAP_ROWS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            run_fill_reg  <= 1'b0;
            run_count_reg <= '0;
            err_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            run_left_reg  <= '0;
            run_val_reg   <= 1'b0;
            val0_reg      <= '0;
            val1_reg      <= '0;
            cur_reg       <= '0;
            dirty_reg     <= '0;
            rd_bank_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            dump_row_reg  <= '0;
            status_reg    <= STATUS_FULL;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.seg_read || cmd.dump_read)
            begin
                rd_bank_reg <= rd_bank;
                rd_ok_reg   <= rd_ok;
            end

            if (cmd.accept)
            begin
                phase_reg     <= phase_next;
                run_fill_reg  <= fill_next;
                run_count_reg <= count_next;
                err_reg       <= err_next;
                trunc_reg     <= trunc_next;
                last_reg      <= char_data.end_of_string;
                if (pos_clr)
                begin
                    pos_reg     <= '0;
                    pos_row_reg <= '0;
                    pos_col_reg <= '0;
                end
                if (launch)
                begin
                    run_left_reg <= launch_len;
                    run_val_reg  <= launch_fill;
                end
            end
            else if (cmd.seg_write)
            begin
                // advance past the segment just written
                if (col_end == (COL_W + 1)'(MAP_COLS))
                begin
                    pos_col_reg <= '0;
                    pos_row_reg <= pos_row_reg + 1'b1;
                end
                else
                begin
                    pos_col_reg <= COL_W'(col_end);
                end
                pos_reg      <= pos_reg + POS_W'(seg_len);
                run_left_reg <= run_left_reg - POS_W'(seg_len);
                dirty_reg[pos_row_reg] <= 1'b1;
                if (wr_bank)
                begin
                    val1_reg[pos_row_reg] <= 1'b1;
                end
                else
                begin
                    val0_reg[pos_row_reg] <= 1'b1;
                end
            end
            else if (cmd.finish)
            begin
                // commit by flipping the bank of every rewritten row, or drop them on error
                if (!err_reg)
                begin
                    cur_reg <= cur_reg ^ dirty_reg;
                end
                dirty_reg     <= '0;
                status_reg    <= status_next;
                dump_row_reg  <= '0;
                phase_reg     <= PH_START;
                run_fill_reg  <= 1'b0;
                run_count_reg <= '0;
                err_reg       <= 1'b0;
                trunc_reg     <= 1'b0;
                last_reg      <= 1'b0;
                pos_reg       <= '0;
                pos_row_reg   <= '0;
                pos_col_reg   <= '0;
            end
            else if (cmd.dump_load)
            begin
                dump_row_reg <= dump_row_reg + 1'b1;
            end

            if (cmd.dump_load)
            begin
                row_valid_reg <= 1'b1;
            end
            else if (row_valid_reg && !row_stall)
            begin
                row_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.run_busy    = (run_left_reg != '0);
    assign sts.string_done = last_reg;
    assign sts.out_busy    = row_valid_reg && row_stall;
    assign sts.dump_last   = (dump_row_reg == ROW_W'(MAP_ROWS - 1));

    assign row_valid = row_valid_reg;
    assign row_data  = row_data_reg;

endmodule

`default_nettype wire
